FILE: hw/rtl/lspt_pkg.sv
`default_nettype none

package lspt_pkg;

   localparam int POS_W   = 13;
   localparam int POS_MIN = -4096;
   localparam int POS_MAX = 4095;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_INVERT          = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNELS_IN_USE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PUBLISH_PERIOD  = 2'd2;

   localparam logic [1:0] LOST_UNKNOWN = 2'd0;
   localparam logic [1:0] LOST_LEFT    = 2'd1;
   localparam logic [1:0] LOST_RIGHT   = 2'd2;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_CHECK  = 6'b000010,
      ST_ACCUM  = 6'b000100,
      ST_DSETUP = 6'b001000,
      ST_DIVIDE = 6'b010000,
      ST_FINISH = 6'b100000
   } state_type;

   typedef struct packed {
      logic load;     // latch the accepted request
      logic prep;     // build masks, clear accumulator
      logic acc;      // add one channel
      logic dload;    // load divider with |sum|
      logic dstep;    // one quotient bit
      logic finish;   // publish and update tracking state
   } cmd_type;

   typedef struct packed {
      logic throttled;
      logic acc_last;
      logic div_last;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

FILE: hw/rtl/lspt_ctrl.sv
`default_nettype none

module lspt_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire lspt_pkg::status_type sts,
   output lspt_pkg::cmd_type        cmd
);

   lspt_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         lspt_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = lspt_pkg::ST_CHECK;
            end
         end
         lspt_pkg::ST_CHECK: begin
            if (sts.throttled) begin
               state_in = lspt_pkg::ST_IDLE;
            end else begin
               cmd.prep = 1'b1;
               state_in = lspt_pkg::ST_ACCUM;
            end
         end
         lspt_pkg::ST_ACCUM: begin
            cmd.acc = 1'b1;
            if (sts.acc_last) state_in = lspt_pkg::ST_DSETUP;
         end
         lspt_pkg::ST_DSETUP: begin
            cmd.dload = 1'b1;
            state_in  = lspt_pkg::ST_DIVIDE;
         end
         lspt_pkg::ST_DIVIDE: begin
            cmd.dstep = 1'b1;
            if (sts.div_last) state_in = lspt_pkg::ST_FINISH;
         end
         lspt_pkg::ST_FINISH: begin
            // hold here while the previous result is still unread
            if (sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = lspt_pkg::ST_IDLE;
            end
         end
         default: state_in = lspt_pkg::ST_IDLE;
      endcase
   end

   assign req_ready = (state_ff == lspt_pkg::ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) state_ff <= lspt_pkg::ST_IDLE;
      else       state_ff <= state_in;
   end

endmodule

`default_nettype wire

FILE: hw/rtl/lspt_dp.sv
`default_nettype none

module lspt_dp #(
   parameter int MAX_CHANNELS = 8,
   parameter int POS_SCALE    = 1000
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire lspt_pkg::cmd_type                   cmd,
   output lspt_pkg::status_type                     sts,
   input  wire logic [7:0]                          req_raw_levels,
   input  wire logic [31:0]                         req_now_ms,
   input  wire logic                                csr_valid,
   input  wire logic [lspt_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [lspt_pkg::CSR_DATA_W-1:0]     csr_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [7:0]                               rsp_level_mask,
   output logic [7:0]                               rsp_hit_mask,
   output logic [3:0]                               rsp_hit_count,
   output logic                                     rsp_on_line,
   output logic signed [lspt_pkg::POS_W-1:0]        rsp_position,
   output logic signed [lspt_pkg::POS_W-1:0]        rsp_avg_position,
   output logic [1:0]                               rsp_miss_side,
   output logic [15:0]                              rsp_lost_polls,
   output logic signed [lspt_pkg::POS_W-1:0]        rsp_remembered_out,
   output logic [7:0]                               rsp_delta_mask,
   output logic [31:0]                              rsp_sequence_number
);

   localparam int PW     = lspt_pkg::POS_W;
   // sum of up to eight slots stays below 28 * POS_SCALE in magnitude
   localparam int W      = $clog2(POS_SCALE + 1) + 6;
   localparam int IDX_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int DCNT_W = $clog2(W);
   localparam logic signed [W-1:0] SCALE_S = W'(POS_SCALE);

   // configuration
   logic        invert_ff;
   logic [3:0]  chan_cfg_ff;
   logic [15:0] period_ff;

   // request and working registers
   logic [7:0]              raw_ff;
   logic [31:0]             now_ff;
   logic [7:0]              lvl_mask_ff;
   logic [7:0]              act_mask_ff;
   logic [IDX_W-1:0]        idx_ff;
   logic signed [W-1:0]     sum_ff;
   logic [3:0]              count_ff;
   logic [W-1:0]            div_ff;
   logic [3:0]              rem_ff;
   logic [DCNT_W-1:0]       dcnt_ff;
   logic                    neg_ff;

   // tracking state
   logic signed [PW-1:0]    mem_pos_ff;
   logic                    mem_valid_ff;
   logic [15:0]             lost_ff;
   logic [7:0]              prev_mask_ff;
   logic [31:0]             pub_count_ff;
   logic [31:0]             last_time_ff;
   logic                    pub_once_ff;

   // output register
   logic                    rsp_valid_ff;
   logic [7:0]              rsp_lvl_mask_ff;
   logic [7:0]              rsp_hit_mask_ff;
   logic [3:0]              rsp_hit_count_ff;
   logic                    rsp_on_line_ff;
   logic signed [PW-1:0]    rsp_position_ff;
   logic signed [PW-1:0]    rsp_weighted_ff;
   logic [1:0]              rsp_miss_side_ff;
   logic [15:0]             rsp_lost_polls_ff;
   logic signed [PW-1:0]    rsp_remembered_ff;
   logic [7:0]              rsp_changed_ff;
   logic [31:0]             rsp_seq_ff;

   // combinational
   logic [3:0]              chan_n;
   logic [7:0]              chmask;
   logic [31:0]             elapsed;
   logic [MAX_CHANNELS-1:0] act_used;
   logic signed [4:0]       centered;
   logic signed [W-1:0]     prod;
   logic signed [W-1:0]     prod_adj;
   logic signed [W-1:0]     slot;
   logic [W-1:0]            abs_sum;
   logic [4:0]              rem_sh;
   logic                    rem_ge;
   logic signed [W-1:0]     quot_s;
   int                      quot_int;
   int                      sat_int;
   logic signed [PW-1:0]    wsat;
   logic                    detected;
   logic signed [PW-1:0]    mem_view;
   logic signed [PW-1:0]    pos_in;
   logic [1:0]              side_in;
   logic [15:0]             lost_in;

   always_comb begin
      if (chan_cfg_ff == 4'd0)                   chan_n = 4'd1;
      else if (chan_cfg_ff > 4'(MAX_CHANNELS))   chan_n = 4'(MAX_CHANNELS);
      else                                       chan_n = chan_cfg_ff;
      for (int i = 0; i < 8; i++) chmask[i] = (4'(i) < chan_n);
   end

   assign elapsed       = now_ff - last_time_ff;
   assign sts.throttled = pub_once_ff && (period_ff != 16'd0) &&
                          (elapsed < {16'd0, period_ff});

   // slot position ((2i - (n-1)) * scale) / 2, rounded toward zero
   assign act_used = act_mask_ff[MAX_CHANNELS-1:0];
   assign centered = $signed(5'({idx_ff, 1'b0})) - $signed({1'b0, chan_n}) + 5'sd1;
   assign prod     = W'(centered) * SCALE_S;
   assign prod_adj = prod + $signed({{(W-1){1'b0}}, prod[W-1]});
   assign slot     = prod_adj >>> 1;
   assign sts.acc_last = (idx_ff == IDX_W'(MAX_CHANNELS - 1));

   assign abs_sum = sum_ff[W-1] ? W'(-sum_ff) : W'(sum_ff);
   assign rem_sh  = {rem_ff, div_ff[W-1]};
   assign rem_ge  = (rem_sh >= {1'b0, count_ff});
   assign sts.div_last = (dcnt_ff == DCNT_W'(W - 1));

   always_comb begin
      quot_s   = neg_ff ? -$signed(div_ff) : $signed(div_ff);
      quot_int = int'(quot_s);
      if (quot_int < lspt_pkg::POS_MIN)      sat_int = lspt_pkg::POS_MIN;
      else if (quot_int > lspt_pkg::POS_MAX) sat_int = lspt_pkg::POS_MAX;
      else                                   sat_int = quot_int;
      wsat = PW'(sat_int);
   end

   assign detected = (count_ff != 4'd0);
   assign mem_view = mem_valid_ff ? mem_pos_ff : '0;
   assign pos_in   = detected ? wsat : mem_view;
   assign lost_in  = (lost_ff == 16'hFFFF) ? lost_ff : lost_ff + 16'd1;

   always_comb begin
      side_in = lspt_pkg::LOST_UNKNOWN;
      if (!detected && mem_valid_ff) begin
         if (mem_pos_ff < 0)      side_in = lspt_pkg::LOST_LEFT;
         else if (mem_pos_ff > 0) side_in = lspt_pkg::LOST_RIGHT;
      end
   end

   assign sts.out_free = !rsp_valid_ff || rsp_ready;

   // configuration and control state
   always_ff @(posedge clock) begin
      if (reset) begin
         invert_ff     <= 1'b0;
         chan_cfg_ff   <= 4'd8;
         period_ff     <= 16'd0;
         mem_pos_ff    <= '0;
         mem_valid_ff  <= 1'b0;
         lost_ff       <= 16'd0;
         prev_mask_ff  <= 8'd0;
         pub_count_ff  <= 32'd0;
         last_time_ff  <= 32'd0;
         pub_once_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               lspt_pkg::CSR_INVERT:          invert_ff   <= csr_data[0];
               lspt_pkg::CSR_CHANNELS_IN_USE: chan_cfg_ff <= csr_data[3:0];
               lspt_pkg::CSR_PUBLISH_PERIOD:  period_ff   <= csr_data;
               default: ;
            endcase
         end
         if (cmd.finish) begin
            if (detected) begin
               mem_pos_ff   <= wsat;
               mem_valid_ff <= 1'b1;
               lost_ff      <= 16'd0;
            end else begin
               lost_ff      <= lost_in;
            end
            pub_count_ff <= pub_count_ff + 32'd1;
            prev_mask_ff <= act_mask_ff;
            last_time_ff <= now_ff;
            pub_once_ff  <= 1'b1;
         end
         if (cmd.finish)     rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         raw_ff <= req_raw_levels;
         now_ff <= req_now_ms;
      end
      if (cmd.prep) begin
         lvl_mask_ff <= raw_ff & chmask;
         act_mask_ff <= (invert_ff ? ~raw_ff : raw_ff) & chmask;
         idx_ff      <= '0;
         sum_ff      <= '0;
         count_ff    <= 4'd0;
      end
      if (cmd.acc) begin
         if (act_used[idx_ff]) begin
            sum_ff   <= sum_ff + slot;
            count_ff <= count_ff + 4'd1;
         end
         idx_ff <= idx_ff + 1'b1;
      end
      if (cmd.dload) begin
         div_ff  <= abs_sum;
         neg_ff  <= sum_ff[W-1];
         rem_ff  <= 4'd0;
         dcnt_ff <= '0;
      end
      if (cmd.dstep) begin
         // restoring division, one quotient bit per cycle
         if (rem_ge) begin
            rem_ff <= 4'(rem_sh - {1'b0, count_ff});
            div_ff <= {div_ff[W-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh[3:0];
            div_ff <= {div_ff[W-2:0], 1'b0};
         end
         dcnt_ff <= dcnt_ff + 1'b1;
      end
      if (cmd.finish) begin
         rsp_lvl_mask_ff      <= lvl_mask_ff;
         rsp_hit_mask_ff      <= act_mask_ff;
         rsp_hit_count_ff     <= count_ff;
         rsp_on_line_ff       <= detected;
         rsp_position_ff      <= pos_in;
         rsp_weighted_ff      <= detected ? wsat : '0;
         rsp_miss_side_ff     <= side_in;
         rsp_lost_polls_ff    <= detected ? 16'd0 : lost_in;
         rsp_remembered_ff    <= pos_in;
         rsp_changed_ff       <= act_mask_ff ^ prev_mask_ff;
         rsp_seq_ff           <= pub_count_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_level_mask      = rsp_lvl_mask_ff;
   assign rsp_hit_mask        = rsp_hit_mask_ff;
   assign rsp_hit_count       = rsp_hit_count_ff;
   assign rsp_on_line         = rsp_on_line_ff;
   assign rsp_position        = rsp_position_ff;
   assign rsp_avg_position    = rsp_weighted_ff;
   assign rsp_miss_side       = rsp_miss_side_ff;
   assign rsp_lost_polls      = rsp_lost_polls_ff;
   assign rsp_remembered_out  = rsp_remembered_ff;
   assign rsp_delta_mask      = rsp_changed_ff;
   assign rsp_sequence_number = rsp_seq_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/line_sensor_position_tracker.sv
// Line sensor position tracker. Each request is one poll of up to eight
// reflective sensors plus a millisecond timestamp; a poll that arrives
// within the publish period of the last publish is dropped without a result,
// otherwise one result is published with the centred weighted line position,
// lost-line tracking and a sequence number. One request is worked on at a
// time: a dropped poll frees the input after the check step, a published one
// after the check, accumulate, divider setup, divide and finish steps. The
// accumulator takes one channel a cycle and the bit-serial divider, of width
// W = clog2(POS_SCALE+1) + 6, one quotient bit a cycle. The result sits in
// an output register, so a new request can be taken while it waits; the
// finish step holds only if the previous result is still unread.
// Configuration writes are always accepted and must be made with no request
// in flight.
`default_nettype none

module line_sensor_position_tracker #(
   parameter int MAX_CHANNELS = 8,
   parameter int POS_SCALE    = 1000
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [7:0]                          req_raw_levels,
   input  wire logic [31:0]                         req_now_ms,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [7:0]                               rsp_level_mask,
   output logic [7:0]                               rsp_hit_mask,
   output logic [3:0]                               rsp_hit_count,
   output logic                                     rsp_on_line,
   output logic signed [lspt_pkg::POS_W-1:0]        rsp_position,
   output logic signed [lspt_pkg::POS_W-1:0]        rsp_avg_position,
   output logic [1:0]                               rsp_miss_side,
   output logic [15:0]                              rsp_lost_polls,
   output logic signed [lspt_pkg::POS_W-1:0]        rsp_remembered_out,
   output logic [7:0]                               rsp_delta_mask,
   output logic [31:0]                              rsp_sequence_number,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [lspt_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [lspt_pkg::CSR_DATA_W-1:0]     csr_data
);

   lspt_pkg::cmd_type    cmd;
   lspt_pkg::status_type sts;

   assign csr_ready = 1'b1;

   lspt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   lspt_dp #(
      .MAX_CHANNELS (MAX_CHANNELS),
      .POS_SCALE    (POS_SCALE)
   ) u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .sts                   (sts),
      .req_raw_levels        (req_raw_levels),
      .req_now_ms            (req_now_ms),
      .csr_valid             (csr_valid),
      .csr_index             (csr_index),
      .csr_data              (csr_data),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_level_mask        (rsp_level_mask),
      .rsp_hit_mask          (rsp_hit_mask),
      .rsp_hit_count         (rsp_hit_count),
      .rsp_on_line           (rsp_on_line),
      .rsp_position          (rsp_position),
      .rsp_avg_position      (rsp_avg_position),
      .rsp_miss_side         (rsp_miss_side),
      .rsp_lost_polls        (rsp_lost_polls),
      .rsp_remembered_out    (rsp_remembered_out),
      .rsp_delta_mask        (rsp_delta_mask),
      .rsp_sequence_number   (rsp_sequence_number)
   );

endmodule

`default_nettype wire

FILE: hw/rtl/lspt_checker.sv
`default_nettype none

module lspt_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_valid,
   input wire logic                         req_ready,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_ready,
   input wire logic [7:0]                   rsp_hit_mask,
   input wire logic [3:0]                   rsp_hit_count,
   input wire logic                         rsp_on_line,
   input wire logic [lspt_pkg::POS_W-1:0]   rsp_avg_position,
   input wire logic [1:0]                   rsp_miss_side,
   input wire logic [15:0]                  rsp_lost_polls
);

   // a result never shows up on the cycle right after a request is taken
   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_valid && req_ready))
      else $error("result appeared one cycle after request");

   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_hit_count == 4'($countones(rsp_hit_mask))))
      else $error("hit count does not match hit mask");

   a_detected_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_on_line |->
         (rsp_lost_polls == 16'd0) && (rsp_miss_side == lspt_pkg::LOST_UNKNOWN))
      else $error("lost fields set while line detected");

   a_lost_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_on_line |->
         (rsp_avg_position == '0) && (rsp_hit_mask == 8'd0) &&
         (rsp_lost_polls != 16'd0))
      else $error("inconsistent lost-line result");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before it was taken");

endmodule

bind line_sensor_position_tracker lspt_checker u_lspt_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_hit_mask     (rsp_hit_mask),
   .rsp_hit_count    (rsp_hit_count),
   .rsp_on_line      (rsp_on_line),
   .rsp_avg_position (rsp_avg_position),
   .rsp_miss_side    (rsp_miss_side),
   .rsp_lost_polls   (rsp_lost_polls)
);

`default_nettype wire

FILE: sim/tb_line_sensor_position_tracker.sv
module tb_line_sensor_position_tracker;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_CHANNELS     = 8;
   localparam int POS_SCALE        = 1000;
   localparam int POS_W            = lspt_pkg::POS_W;
   localparam int IDX_W            = lspt_pkg::CSR_IDX_W;
   localparam int DATA_W           = lspt_pkg::CSR_DATA_W;
   // accumulator plus bit-serial divider plus control steps plus a little slack
   localparam int BUSY_CYCLES      = MAX_CHANNELS + $clog2(POS_SCALE + 1) + 14;
   localparam int LIMIT_CYCLES     = 800000;
   localparam int RANDOM_PER_PHASE = 165;
   localparam int NUM_PHASES       = 8;
   localparam logic [IDX_W-1:0] CSR_SPARE = 2'd3;

   typedef struct {
      logic [7:0]              level_mask;
      logic [7:0]              hit_mask;
      logic [3:0]              hit_count;
      logic                    on_line;
      logic signed [POS_W-1:0] position;
      logic signed [POS_W-1:0] avg_position;
      logic [1:0]              miss_side;
      logic [15:0]             lost_polls;
      logic signed [POS_W-1:0] remembered;
      logic [7:0]              delta_mask;
      logic [31:0]             sequence_number;
   } publish_type;

   class tracker_score_type;
      bit          invert;
      logic [3:0]  channels;
      logic [15:0] period;
      int          mem_pos;
      bit          mem_valid;
      int unsigned lost_cnt;
      logic [7:0]  prev_mask;
      logic [31:0] pub_count;
      logic [31:0] last_time;
      bit          published;
      publish_type pending_publishes[$];
      int          errors;

      function new();
         invert     = 1'b0;
         channels   = 4'd8;
         period     = 16'd0;
         mem_pos    = 0;
         mem_valid  = 1'b0;
         lost_cnt   = 0;
         prev_mask  = 8'h00;
         pub_count  = 32'd0;
         last_time  = 32'd0;
         published  = 1'b0;
         errors     = 0;
      endfunction

      function void write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
         case (idx)
            lspt_pkg::CSR_INVERT:          invert = data[0];
            lspt_pkg::CSR_CHANNELS_IN_USE: channels = data[3:0];
            lspt_pkg::CSR_PUBLISH_PERIOD:  period = data[15:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return pending_publishes.size();
      endfunction

      function void note_poll(logic [7:0] raw, logic [31:0] now);
         int          n;
         int          count;
         int          sum;
         int          weighted;
         int          pos;
         int          remembered;
         logic [7:0]  chmask;
         logic [7:0]  act;
         logic [31:0] elapsed;
         logic [15:0] lost_out;
         logic [1:0]  side;
         publish_type r;

         n = (channels == 0) ? 1 :
             ((channels > MAX_CHANNELS) ? MAX_CHANNELS : int'(channels));
         elapsed = now - last_time;
         if (published && period != 16'd0 && elapsed < {16'd0, period})
            return;

         chmask   = 8'((1 << n) - 1);
         act      = (invert ? ~raw : raw) & chmask;
         count    = 0;
         sum      = 0;
         weighted = 0;
         side     = lspt_pkg::LOST_UNKNOWN;
         lost_out = 16'd0;
         for (int i = 0; i < n; i++) begin
            if (act[i]) begin
               count++;
               sum += ((2 * i - (n - 1)) * POS_SCALE) / 2;
            end
         end

         if (count != 0) begin
            weighted = sum / count;
            if (weighted < lspt_pkg::POS_MIN)
               weighted = lspt_pkg::POS_MIN;
            else if (weighted > lspt_pkg::POS_MAX)
               weighted = lspt_pkg::POS_MAX;
            pos        = weighted;
            mem_pos    = weighted;
            mem_valid  = 1'b1;
            lost_cnt   = 0;
         end else begin
            if (lost_cnt < 65535)
               lost_cnt++;
            pos = mem_valid ? mem_pos : 0;
            if (mem_valid && mem_pos < 0)
               side = lspt_pkg::LOST_LEFT;
            else if (mem_valid && mem_pos > 0)
               side = lspt_pkg::LOST_RIGHT;
            lost_out = 16'(lost_cnt);
         end
         remembered = mem_valid ? mem_pos : 0;

         r.level_mask      = raw & chmask;
         r.hit_mask        = act;
         r.hit_count       = 4'(count);
         r.on_line         = (count != 0);
         r.position        = POS_W'(pos);
         r.avg_position    = POS_W'(weighted);
         r.miss_side       = side;
         r.lost_polls      = lost_out;
         r.remembered      = POS_W'(remembered);
         r.delta_mask      = act ^ prev_mask;
         r.sequence_number = pub_count;
         pending_publishes.push_back(r);

         pub_count++;
         prev_mask = act;
         last_time = now;
         published = 1'b1;
      endfunction

      function void compare_field(string field, logic signed [32:0] want,
                                  logic signed [32:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
         end
      endfunction

      function void check_publish(publish_type got);
         publish_type want;

         if (pending_publishes.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, got sequence_number %0d",
                     $time, got.sequence_number);
            return;
         end
         want = pending_publishes.pop_front();
         compare_field("rsp_level_mask", want.level_mask, got.level_mask);
         compare_field("rsp_hit_mask", want.hit_mask, got.hit_mask);
         compare_field("rsp_hit_count", want.hit_count, got.hit_count);
         compare_field("rsp_on_line", want.on_line, got.on_line);
         compare_field("position", want.position, got.position);
         compare_field("rsp_avg_position", want.avg_position, got.avg_position);
         compare_field("rsp_miss_side", want.miss_side, got.miss_side);
         compare_field("lost_polls", want.lost_polls, got.lost_polls);
         compare_field("remembered_out", want.remembered, got.remembered);
         compare_field("rsp_delta_mask", want.delta_mask, got.delta_mask);
         compare_field("sequence_number", want.sequence_number, got.sequence_number);
      endfunction
   endclass

   logic                    clock;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [7:0]              req_raw_levels = 8'h00;
   logic [31:0]             req_now_ms = 32'd0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b1;
   logic [7:0]              rsp_level_mask;
   logic [7:0]              rsp_hit_mask;
   logic [3:0]              rsp_hit_count;
   logic                    rsp_on_line;
   logic signed [POS_W-1:0] rsp_position;
   logic signed [POS_W-1:0] rsp_avg_position;
   logic [1:0]              rsp_miss_side;
   logic [15:0]             rsp_lost_polls;
   logic signed [POS_W-1:0] rsp_remembered_out;
   logic [7:0]              rsp_delta_mask;
   logic [31:0]             rsp_sequence_number;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [IDX_W-1:0]        csr_index = '0;
   logic [DATA_W-1:0]       csr_data = '0;

   tracker_score_type score = new();

   int req_idle_pct  = 0;
   int rsp_stall_pct = 0;
   int lost_run      = 0;
   int cycle_count   = 0;

   // directed polls at reset settings: 8 channels, active high, no throttling
   logic [7:0]  dir_levels [17] = '{8'h00, 8'h01, 8'h00, 8'h80, 8'h00, 8'hFF, 8'h00, 8'h18,
                                    8'h00, 8'h07, 8'h55, 8'hAA, 8'hC0, 8'h83, 8'h86, 8'hC1,
                                    8'h00};
   logic [31:0] dir_times [17]  = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000,
                                    32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA,
                                    32'h0000_0001, 32'h1234_5678, 32'hFEDC_BA98,
                                    32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h3333_3333,
                                    32'hCCCC_CCCC, 32'h0000_FFFF, 32'hFFFF_0000,
                                    32'h00FF_FF00, 32'h7FFF_0000};
   // inverted polarity, 5 channels, period 10: throttle boundary across the time wrap
   logic [7:0]  thr_levels [8]  = '{8'hFB, 8'h1F, 8'h3F, 8'hFE, 8'hBF, 8'h9F, 8'hEF, 8'h7F};
   logic [31:0] thr_times [8]   = '{32'hFFFF_FFF0, 32'hFFFF_FFF5, 32'hFFFF_FFF9,
                                    32'hFFFF_FFFA, 32'h0000_0003, 32'h0000_0004,
                                    32'h0000_000E, 32'h0000_001E};

   bit          phase_low [NUM_PHASES]      = '{1'b1, 1'b0, 1'b1, 1'b0,
                                                1'b1, 1'b0, 1'b1, 1'b0};
   logic [3:0]  phase_channels [NUM_PHASES] = '{4'd8, 4'd1, 4'd3, 4'd0,
                                                4'd15, 4'd4, 4'd7, 4'd9};
   logic [15:0] phase_period [NUM_PHASES]   = '{16'd0, 16'd5, 16'd100, 16'd65535,
                                                16'd1, 16'd20, 16'd0, 16'd3};

   line_sensor_position_tracker #(
      .MAX_CHANNELS(MAX_CHANNELS),
      .POS_SCALE   (POS_SCALE)
   ) dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_raw_levels       (req_raw_levels),
      .req_now_ms           (req_now_ms),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_level_mask       (rsp_level_mask),
      .rsp_hit_mask         (rsp_hit_mask),
      .rsp_hit_count        (rsp_hit_count),
      .rsp_on_line          (rsp_on_line),
      .rsp_position         (rsp_position),
      .rsp_avg_position     (rsp_avg_position),
      .rsp_miss_side        (rsp_miss_side),
      .rsp_lost_polls       (rsp_lost_polls),
      .rsp_remembered_out   (rsp_remembered_out),
      .rsp_delta_mask       (rsp_delta_mask),
      .rsp_sequence_number  (rsp_sequence_number),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // called just after a falling edge; returns just after one, valid still high
   task automatic send_poll(input logic [7:0] raw, input logic [31:0] now);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid      = 1'b1;
      req_raw_levels = raw;
      req_now_ms     = now;
      do @(posedge clock); while (!req_ready);
      score.note_poll(raw, now);
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = data;
      do @(posedge clock); while (!csr_ready);
      score.write_reg(idx, data);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // dropped polls leave no trace, so let the block go quiet before touching config
   task automatic settle();
      req_valid = 1'b0;
      while (score.pending() != 0) @(negedge clock);
      repeat (2 * BUSY_CYCLES) @(negedge clock);
   endtask

   function automatic logic [7:0] pick_levels(int n, bit low_active);
      logic [7:0] chmask;
      logic [7:0] act;
      int         pick;

      chmask = 8'((1 << n) - 1);
      pick   = $urandom_range(99);
      if (lost_run > 0) begin
         lost_run--;
         act = 8'h00;
      end else if (pick < 8) begin
         lost_run = $urandom_range(4, 40);
         act = 8'h00;
      end else if (pick < 25)
         act = 8'h00;
      else if (pick < 45)
         act = 8'(1 << $urandom_range(n - 1));
      else if (pick < 60)
         act = 8'(3 << $urandom_range(n - 1));
      else if (pick < 65)
         act = 8'hFF;
      else if (pick < 90)
         act = 8'($urandom);
      else
         return 8'($urandom);
      act &= chmask;
      return ((low_active ? ~act : act) & chmask) | (8'($urandom) & ~chmask);
   endfunction

   // mostly steps around the period so both sides of the throttle get hit
   function automatic logic [31:0] next_time(logic [31:0] t, logic [15:0] per);
      int pick;

      pick = $urandom_range(99);
      if (per == 16'd0 || pick < 10)
         return $urandom;
      if (pick < 20)
         return t + per - 32'd1;
      if (pick < 30)
         return t + per;
      if (pick < 35)
         return t;
      return t + $urandom_range(0, 2 * per);
   endfunction

   task automatic set_idling(input int mode);
      case (mode)
         0: begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
         1: begin req_idle_pct = 73; rsp_stall_pct = 0;  end
         2: begin req_idle_pct = 0;  rsp_stall_pct = 73; end
         default: begin req_idle_pct = 18; rsp_stall_pct = 18; end
      endcase
   endtask

   initial begin
      forever begin
         @(negedge clock);
         rsp_ready = ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   initial begin
      publish_type got;

      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            got.level_mask      = rsp_level_mask;
            got.hit_mask        = rsp_hit_mask;
            got.hit_count       = rsp_hit_count;
            got.on_line         = rsp_on_line;
            got.position        = rsp_position;
            got.avg_position    = rsp_avg_position;
            got.miss_side       = rsp_miss_side;
            got.lost_polls      = rsp_lost_polls;
            got.remembered      = rsp_remembered_out;
            got.delta_mask      = rsp_delta_mask;
            got.sequence_number = rsp_sequence_number;
            score.check_publish(got);
         end
      end
   end

   initial begin
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("line_sensor_position_tracker: mismatch");
      $finish;
   end

   initial begin
      int          n;
      logic [31:0] tnow;

      tnow = 32'd0;
      repeat (3) @(negedge clock);
      reset = 1'b0;

      set_idling(0);
      for (int i = 0; i < 17; i++)
         send_poll(dir_levels[i], dir_times[i]);

      settle();
      write_csr(lspt_pkg::CSR_INVERT, 16'hA5A5);
      write_csr(lspt_pkg::CSR_CHANNELS_IN_USE, 16'h3C05);
      write_csr(lspt_pkg::CSR_PUBLISH_PERIOD, 16'd10);
      write_csr(CSR_SPARE, 16'($urandom));
      for (int i = 0; i < 8; i++)
         send_poll(thr_levels[i], thr_times[i]);

      for (int p = 0; p < NUM_PHASES; p++) begin
         settle();
         write_csr(lspt_pkg::CSR_INVERT, {15'($urandom), phase_low[p]});
         write_csr(lspt_pkg::CSR_CHANNELS_IN_USE, {12'($urandom), phase_channels[p]});
         write_csr(lspt_pkg::CSR_PUBLISH_PERIOD, phase_period[p]);
         write_csr(CSR_SPARE, 16'($urandom));
         set_idling(p % 4);
         n = (phase_channels[p] == 0) ? 1 :
             ((phase_channels[p] > MAX_CHANNELS) ? MAX_CHANNELS : int'(phase_channels[p]));
         lost_run = 0;
         for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
            tnow = next_time(tnow, phase_period[p]);
            send_poll(pick_levels(n, phase_low[p]), tnow);
         end
      end

      settle();
      if (score.errors == 0)
         $display("line_sensor_position_tracker: match");
      else
         $display("line_sensor_position_tracker: mismatch");
      $finish;
   end

endmodule
